// ===== rtl/core/cnp_pkg.sv =====
// Shared types, widths and codes for the capsule nearest-point block.
// No dependencies; every other file in rtl/core imports this package.
package cnp_pkg;

  // Coordinate and datapath widths
  localparam int CW  = 32;        // coordinate, signed fixed point
  localparam int DW  = CW + 1;    // coordinate difference
  localparam int PW  = 2 * DW;    // product of two differences
  localparam int SW  = PW + 1;    // dot product (sum of two products)
  localparam int RW  = CW - 1;    // radius, unsigned
  localparam int QW  = DW;        // quotient / root width
  localparam int NW  = QW + PW;   // dividend width
  localparam int LAT = QW;        // divider and root stage count, one bit per stage

  // Configuration register indexes
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_START_X = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_START_Y = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_END_X   = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_END_Y   = CFG_AW'(3);
  localparam logic [CFG_AW-1:0] REG_RADIUS  = CFG_AW'(4);

  // Front-to-back queue
  localparam int QDEPTH  = 8;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = QAW + 1;
  localparam int FSTAGES = 4;
  localparam int FSW     = $clog2(FSTAGES + 1);
  typedef logic [QCW:0] occ_t;

  // Which disc center an item is pulled toward
  typedef enum logic [1:0] {
    CLS_START = 2'd0,
    CLS_END   = 2'd1,
    CLS_PROJ  = 2'd2
  } cls_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic [RW-1:0]        rad;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic [PW-1:0]        dotm;
    logic [PW-1:0]        l2;
    cls_t                 cls;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } xfer_t;

endpackage

// ===== rtl/core/cnp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cnp_pkg; quotient must fit in QW bits.
module cnp_div import cnp_pkg::*; (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [PW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [PW-1:0] rem_r [0:LAT-1];
  logic [PW-1:0] den_r [0:LAT-1];
  logic [QW-1:0] low_r [0:LAT-1];
  logic [QW-1:0] quo_r [0:LAT-1];

  for (genvar k = 0; k < LAT; k++) begin : g_step
    logic [PW-1:0] rem_i;
    logic [PW-1:0] dv;
    logic [QW-1:0] low_i;
    logic [QW-1:0] quo_i;
    logic [PW:0]   trial;
    logic [PW:0]   dif;
    logic          ge;
    logic [PW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_i = num_i[NW-1:QW];
      assign low_i = num_i[QW-1:0];
      assign quo_i = '0;
      assign dv    = den_i;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign quo_i = quo_r[k-1];
      assign dv    = den_r[k-1];
    end

    assign trial   = {rem_i, low_i[QW-1]};
    assign dif     = trial - {1'b0, dv};
    assign ge      = trial >= {1'b0, dv};
    assign rem_nxt = ge ? dif[PW-1:0] : trial[PW-1:0];

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= dv;
      low_r[k] <= {low_i[QW-2:0], 1'b0};
      quo_r[k] <= {quo_i[QW-2:0], ge};
    end
  end

  assign quo_o = quo_r[LAT-1];

endmodule

// ===== rtl/core/cnp_sqrt.sv =====
// Pipelined integer square root (floor), one root bit per stage.
// Depends on cnp_pkg; radicand is PW bits, root QW bits.
module cnp_sqrt import cnp_pkg::*; (
  input  logic          clk,
  input  logic [PW-1:0] rad_i,
  output logic [QW-1:0] root_o
);

  logic [PW-1:0] rem_r  [0:LAT-1];
  logic [QW-1:0] root_r [0:LAT-1];

  for (genvar k = 0; k < LAT; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [PW-1:0] rem_i;
    logic [QW-1:0] root_i;
    logic [PW:0]   term;
    logic [PW:0]   dif;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i  = rad_i;
      assign root_i = '0;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    // rem holds v - root^2; trying bit B costs 2*root*2^B + 2^(2B)
    assign term = ({{(PW + 1 - QW){1'b0}}, root_i} << (B + 1))
                | ({{PW{1'b0}}, 1'b1} << (2 * B));
    assign dif  = {1'b0, rem_i} - term;
    assign ge   = {1'b0, rem_i} >= term;

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? dif[PW-1:0] : rem_i;
      root_r[k] <= ge ? (root_i | (QW'(1) << B)) : root_i;
    end
  end

  assign root_o = root_r[LAT-1];

endmodule

// ===== rtl/core/cnp_front.sv =====
// Front end: takes query points, forms the bone dot products and classifies.
// Depends on cnp_pkg; feeds cnp_queue.
module cnp_front import cnp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 acc,
  input  logic signed [CW-1:0] qx,
  input  logic signed [CW-1:0] qy,
  output xfer_t                push,
  output logic [FSW-1:0]       inflight
);

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [CW-1:0] qx1_r, qy1_r, qx2_r, qy2_r, qx3_r, qy3_r;
  logic signed [DW-1:0] ux_r, uy_r;
  logic signed [PW-1:0] pxx_r, pyy_r, ldx_r, ldy_r;
  logic signed [SW-1:0] dot_r;
  logic [PW-1:0]        l2_r;
  item_t                item_r;
  cls_t                 cls_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // classify against the bone
  always_comb begin
    if (cfg.dx == '0 && cfg.dy == '0) begin
      cls_nxt = CLS_START;
    end else if (dot_r[SW-1]) begin
      cls_nxt = CLS_START;
    end else if (dot_r > $signed({1'b0, l2_r})) begin
      cls_nxt = CLS_END;
    end else begin
      cls_nxt = CLS_PROJ;
    end
  end

  always_ff @(posedge clk) begin
    qx1_r <= qx;
    qy1_r <= qy;
    ux_r  <= {qx[CW-1], qx} - {cfg.sx[CW-1], cfg.sx};
    uy_r  <= {qy[CW-1], qy} - {cfg.sy[CW-1], cfg.sy};

    qx2_r <= qx1_r;
    qy2_r <= qy1_r;
    pxx_r <= cfg.dx * ux_r;
    pyy_r <= cfg.dy * uy_r;
    ldx_r <= cfg.dx * cfg.dx;
    ldy_r <= cfg.dy * cfg.dy;

    qx3_r <= qx2_r;
    qy3_r <= qy2_r;
    dot_r <= SW'(pxx_r) + SW'(pyy_r);
    l2_r  <= $unsigned(ldx_r) + $unsigned(ldy_r);

    item_r.qx   <= qx3_r;
    item_r.qy   <= qy3_r;
    item_r.dotm <= dot_r[PW-1:0];
    item_r.l2   <= l2_r;
    item_r.cls  <= cls_nxt;
  end

  assign push.vld  = v4_r;
  assign push.item = item_r;
  assign inflight  = FSW'(v1_r) + FSW'(v2_r) + FSW'(v3_r) + FSW'(v4_r);

endmodule

// ===== rtl/core/cnp_queue.sv =====
// Short FIFO between front and back; drains one entry per cycle.
// Depends on cnp_pkg.
module cnp_queue import cnp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  xfer_t          push,
  output xfer_t          pop,
  output logic [QCW-1:0] cnt
);

  item_t          mem [0:QDEPTH-1];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           pop_v_r;
  item_t          pop_item_r;
  logic           do_pop;

  assign do_pop = cnt_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      pop_v_r  <= 1'b0;
    end else begin
      if (push.vld) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r   <= cnt_r + QCW'(push.vld) - QCW'(do_pop);
      pop_v_r <= do_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) mem[wr_ptr_r] <= push.item;
    pop_item_r <= mem[rd_ptr_r];
  end

  assign pop.vld  = pop_v_r;
  assign pop.item = pop_item_r;
  assign cnt      = cnt_r;

endmodule

// ===== rtl/core/cnp_back.sv =====
// Back end: projection division, disc pull via root and scale division.
// Depends on cnp_pkg, cnp_div and cnp_sqrt.
module cnp_back import cnp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  xfer_t                pop,
  output logic                 out_v,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic                 out_in
);

  localparam int XW = CW + 2;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [XW-1:0] v);
    logic signed [CW-1:0] r;
    if (v[XW-1:CW-1] == {(XW - CW + 1){v[XW-1]}}) begin
      r = v[CW-1:0];
    end else if (v[XW-1]) begin
      r = {1'b1, {(CW - 1){1'b0}}};
    end else begin
      r = {1'b0, {(CW - 1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // projection multiply
  logic                 s1_v_r, s2_v_r;
  logic [PW-1:0]        phx_r, plx_r, phy_r, ply_r, l2_1_r, l2_2_r;
  logic signed [CW-1:0] qx1_r, qy1_r, qx2_r, qy2_r;
  cls_t                 cls1_r, cls2_r;
  logic [NW-1:0]        numx_r, numy_r;
  logic [DW-1:0]        adx, ady;
  logic [QW-1:0]        px_q, py_q;

  assign adx = mag(cfg.dx);
  assign ady = mag(cfg.dy);

  always_ff @(posedge clk) begin
    phx_r  <= adx * pop.item.dotm[PW-1:QW];
    plx_r  <= adx * pop.item.dotm[QW-1:0];
    phy_r  <= ady * pop.item.dotm[PW-1:QW];
    ply_r  <= ady * pop.item.dotm[QW-1:0];
    l2_1_r <= pop.item.l2;
    qx1_r  <= pop.item.qx;
    qy1_r  <= pop.item.qy;
    cls1_r <= pop.item.cls;

    numx_r <= {phx_r, {QW{1'b0}}} + NW'(plx_r);
    numy_r <= {phy_r, {QW{1'b0}}} + NW'(ply_r);
    l2_2_r <= l2_1_r;
    qx2_r  <= qx1_r;
    qy2_r  <= qy1_r;
    cls2_r <= cls1_r;
  end

  cnp_div u_div_px (.clk(clk), .num_i(numx_r), .den_i(l2_2_r), .quo_o(px_q));
  cnp_div u_div_py (.clk(clk), .num_i(numy_r), .den_i(l2_2_r), .quo_o(py_q));

  logic [LAT-1:0]       va_r;
  logic signed [CW-1:0] qxa_r [0:LAT-1];
  logic signed [CW-1:0] qya_r [0:LAT-1];
  cls_t                 clsa_r [0:LAT-1];

  always_ff @(posedge clk) begin
    qxa_r[0]  <= qx2_r;
    qya_r[0]  <= qy2_r;
    clsa_r[0] <= cls2_r;
    for (int i = 1; i < LAT; i++) begin
      qxa_r[i]  <= qxa_r[i-1];
      qya_r[i]  <= qya_r[i-1];
      clsa_r[i] <= clsa_r[i-1];
    end
  end

  // center of the disc
  logic                 s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic signed [XW-1:0] cpx, cpy;
  logic signed [CW-1:0] cx_nxt, cy_nxt;
  logic signed [CW-1:0] cx3_r, cy3_r, qx3_r, qy3_r, cx4_r, cy4_r, qx4_r, qy4_r;
  logic signed [CW-1:0] cx5_r, cy5_r, qx5_r, qy5_r, cx6_r, cy6_r, qx6_r, qy6_r;
  logic signed [DW-1:0] vx4_r, vy4_r, vx5_r, vy5_r, vx6_r, vy6_r;
  logic signed [PW-1:0] sqx_r, sqy_r;
  logic [PW-1:0]        d2_r, r2_r;

  always_comb begin
    cpx = {{2{cfg.sx[CW-1]}}, cfg.sx}
        + (cfg.dx[DW-1] ? -$signed({1'b0, px_q}) : $signed({1'b0, px_q}));
    cpy = {{2{cfg.sy[CW-1]}}, cfg.sy}
        + (cfg.dy[DW-1] ? -$signed({1'b0, py_q}) : $signed({1'b0, py_q}));
    case (clsa_r[LAT-1])
      CLS_START: begin
        cx_nxt = cfg.sx;
        cy_nxt = cfg.sy;
      end
      CLS_END: begin
        cx_nxt = cfg.ex;
        cy_nxt = cfg.ey;
      end
      CLS_PROJ: begin
        cx_nxt = cpx[CW-1:0];
        cy_nxt = cpy[CW-1:0];
      end
      default: begin
        cx_nxt = cfg.sx;
        cy_nxt = cfg.sy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cx3_r <= cx_nxt;
    cy3_r <= cy_nxt;
    qx3_r <= qxa_r[LAT-1];
    qy3_r <= qya_r[LAT-1];

    vx4_r <= {qx3_r[CW-1], qx3_r} - {cx3_r[CW-1], cx3_r};
    vy4_r <= {qy3_r[CW-1], qy3_r} - {cy3_r[CW-1], cy3_r};
    cx4_r <= cx3_r;
    cy4_r <= cy3_r;
    qx4_r <= qx3_r;
    qy4_r <= qy3_r;

    sqx_r <= vx4_r * vx4_r;
    sqy_r <= vy4_r * vy4_r;
    vx5_r <= vx4_r;
    vy5_r <= vy4_r;
    cx5_r <= cx4_r;
    cy5_r <= cy4_r;
    qx5_r <= qx4_r;
    qy5_r <= qy4_r;

    d2_r  <= $unsigned(sqx_r) + $unsigned(sqy_r);
    r2_r  <= cfg.rad * cfg.rad;
    vx6_r <= vx5_r;
    vy6_r <= vy5_r;
    cx6_r <= cx5_r;
    cy6_r <= cy5_r;
    qx6_r <= qx5_r;
    qy6_r <= qy5_r;
  end

  // distance root, payload rides alongside
  logic [QW-1:0]        len_q;
  logic [LAT-1:0]       vb_r;
  logic signed [CW-1:0] qxb_r [0:LAT-1];
  logic signed [CW-1:0] qyb_r [0:LAT-1];
  logic signed [CW-1:0] cxb_r [0:LAT-1];
  logic signed [CW-1:0] cyb_r [0:LAT-1];
  logic signed [DW-1:0] vxb_r [0:LAT-1];
  logic signed [DW-1:0] vyb_r [0:LAT-1];
  logic                 inb_r [0:LAT-1];

  cnp_sqrt u_sqrt (.clk(clk), .rad_i(d2_r), .root_o(len_q));

  always_ff @(posedge clk) begin
    qxb_r[0] <= qx6_r;
    qyb_r[0] <= qy6_r;
    cxb_r[0] <= cx6_r;
    cyb_r[0] <= cy6_r;
    vxb_r[0] <= vx6_r;
    vyb_r[0] <= vy6_r;
    inb_r[0] <= d2_r <= r2_r;
    for (int i = 1; i < LAT; i++) begin
      qxb_r[i] <= qxb_r[i-1];
      qyb_r[i] <= qyb_r[i-1];
      cxb_r[i] <= cxb_r[i-1];
      cyb_r[i] <= cyb_r[i-1];
      vxb_r[i] <= vxb_r[i-1];
      vyb_r[i] <= vyb_r[i-1];
      inb_r[i] <= inb_r[i-1];
    end
  end

  // scale to the radius
  logic                   s7_v_r;
  logic [DW+RW-1:0]       mx_r, my_r;
  logic [QW-1:0]          len_r;
  logic signed [CW-1:0]   qx7_r, qy7_r, cx7_r, cy7_r;
  logic                   vxn7_r, vyn7_r, in7_r;
  logic [QW-1:0]          sx_q, sy_q;

  always_ff @(posedge clk) begin
    mx_r   <= mag(vxb_r[LAT-1]) * cfg.rad;
    my_r   <= mag(vyb_r[LAT-1]) * cfg.rad;
    len_r  <= len_q;
    qx7_r  <= qxb_r[LAT-1];
    qy7_r  <= qyb_r[LAT-1];
    cx7_r  <= cxb_r[LAT-1];
    cy7_r  <= cyb_r[LAT-1];
    vxn7_r <= vxb_r[LAT-1][DW-1];
    vyn7_r <= vyb_r[LAT-1][DW-1];
    in7_r  <= inb_r[LAT-1];
  end

  cnp_div u_div_sx (.clk(clk), .num_i(NW'(mx_r)), .den_i(PW'(len_r)), .quo_o(sx_q));
  cnp_div u_div_sy (.clk(clk), .num_i(NW'(my_r)), .den_i(PW'(len_r)), .quo_o(sy_q));

  logic [LAT-1:0]       vc_r;
  logic signed [CW-1:0] qxc_r [0:LAT-1];
  logic signed [CW-1:0] qyc_r [0:LAT-1];
  logic signed [CW-1:0] cxc_r [0:LAT-1];
  logic signed [CW-1:0] cyc_r [0:LAT-1];
  logic                 vxnc_r [0:LAT-1];
  logic                 vync_r [0:LAT-1];
  logic                 inc_r [0:LAT-1];

  always_ff @(posedge clk) begin
    qxc_r[0]  <= qx7_r;
    qyc_r[0]  <= qy7_r;
    cxc_r[0]  <= cx7_r;
    cyc_r[0]  <= cy7_r;
    vxnc_r[0] <= vxn7_r;
    vync_r[0] <= vyn7_r;
    inc_r[0]  <= in7_r;
    for (int i = 1; i < LAT; i++) begin
      qxc_r[i]  <= qxc_r[i-1];
      qyc_r[i]  <= qyc_r[i-1];
      cxc_r[i]  <= cxc_r[i-1];
      cyc_r[i]  <= cyc_r[i-1];
      vxnc_r[i] <= vxnc_r[i-1];
      vync_r[i] <= vync_r[i-1];
      inc_r[i]  <= inc_r[i-1];
    end
  end

  // final point
  logic signed [XW-1:0] fx, fy;
  logic signed [CW-1:0] ox_nxt, oy_nxt;
  logic signed [CW-1:0] ox_r, oy_r;
  logic                 oin_r, ov_r;

  always_comb begin
    fx = {{2{cxc_r[LAT-1][CW-1]}}, cxc_r[LAT-1]}
       + (vxnc_r[LAT-1] ? -$signed({1'b0, sx_q}) : $signed({1'b0, sx_q}));
    fy = {{2{cyc_r[LAT-1][CW-1]}}, cyc_r[LAT-1]}
       + (vync_r[LAT-1] ? -$signed({1'b0, sy_q}) : $signed({1'b0, sy_q}));
    if (inc_r[LAT-1]) begin
      ox_nxt = qxc_r[LAT-1];
      oy_nxt = qyc_r[LAT-1];
    end else begin
      ox_nxt = sat_c(fx);
      oy_nxt = sat_c(fy);
    end
  end

  always_ff @(posedge clk) begin
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
    oin_r <= (ox_nxt == qxc_r[LAT-1]) && (oy_nxt == qyc_r[LAT-1]);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      va_r   <= '0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      vb_r   <= '0;
      s7_v_r <= 1'b0;
      vc_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      s1_v_r <= pop.vld;
      s2_v_r <= s1_v_r;
      va_r   <= {va_r[LAT-2:0], s2_v_r};
      s3_v_r <= va_r[LAT-1];
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      vb_r   <= {vb_r[LAT-2:0], s6_v_r};
      s7_v_r <= vb_r[LAT-1];
      vc_r   <= {vc_r[LAT-2:0], s7_v_r};
      ov_r   <= vc_r[LAT-1];
    end
  end

  assign out_v  = ov_r;
  assign out_x  = ox_r;
  assign out_y  = oy_r;
  assign out_in = oin_r;

endmodule

// ===== rtl/core/capsule_nearest_point.sv =====
// Top level of the capsule nearest-point block: config registers and busy.
// Depends on cnp_pkg, cnp_front, cnp_queue and cnp_back.
//
//   channel  ports                                  transfer when
//   -------  -------------------------------------  ---------------------
//   input    start, busy, in_query_x/y             start && !busy
//   result   out_valid, out_near_x/y, out_inside_res out_valid (one cycle)
//   config   cfg_we, cfg_index, cfg_data           cfg_we
//
// One query per cycle sustained while busy is low; each query passes through
// two 33-stage dividers and the 33-stage square root, each retiring one
// bit per stage.
// Reset (rst_n low, synchronous) clears the capsule registers and all valid
// flags; no clearing pass. The receiver cannot stall; busy rises only if the
// front-to-back queue plus items in the front would overflow it.

module capsule_nearest_point import cnp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_query_x,
  input  logic signed [CW-1:0] in_query_y,
  input  logic                 cfg_we,
  input  logic [CFG_AW-1:0]    cfg_index,
  input  logic [CW-1:0]        cfg_data,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_near_x,
  output logic signed [CW-1:0] out_near_y,
  output logic                 out_inside_res
);

  // Capsule registers; bone deltas are kept registered beside them, one register
  // behind the endpoints. The block does not hold queries off while they settle.
  logic signed [CW-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [RW-1:0]        rad_r;
  logic signed [DW-1:0] dx_r, dy_r;
  cfg_t                 cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r  <= '0;
      sy_r  <= '0;
      ex_r  <= '0;
      ey_r  <= '0;
      rad_r <= '0;
      dx_r  <= '0;
      dy_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X: sx_r  <= cfg_data;
          REG_START_Y: sy_r  <= cfg_data;
          REG_END_X:   ex_r  <= cfg_data;
          REG_END_Y:   ey_r  <= cfg_data;
          REG_RADIUS:  rad_r <= cfg_data[RW-1:0];
          default: ;   // unused index: write dropped
        endcase
      end
      dx_r <= {ex_r[CW-1], ex_r} - {sx_r[CW-1], sx_r};
      dy_r <= {ey_r[CW-1], ey_r} - {sy_r[CW-1], sy_r};
    end
  end

  assign cfg.sx  = sx_r;
  assign cfg.sy  = sy_r;
  assign cfg.ex  = ex_r;
  assign cfg.ey  = ey_r;
  assign cfg.rad = rad_r;
  assign cfg.dx  = dx_r;
  assign cfg.dy  = dy_r;

  // Front: dot products and start / end / projection classification
  xfer_t          push, pop;
  logic [FSW-1:0] f_inflight;
  logic [QCW-1:0] q_cnt;
  logic           acc;

  // Hold off input only when every queue slot is spoken for
  assign busy = (occ_t'(q_cnt) + occ_t'(f_inflight)) >= occ_t'(QDEPTH);
  assign acc  = start && !busy;

  cnp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .acc      (acc),
    .qx       (in_query_x),
    .qy       (in_query_y),
    .push     (push),
    .inflight (f_inflight)
  );

  // Queue decouples the front from the back
  cnp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .cnt   (q_cnt)
  );

  // Back: projection, distance root, clamp to radius, saturate
  cnp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .pop    (pop),
    .out_v  (out_valid),
    .out_x  (out_near_x),
    .out_y  (out_near_y),
    .out_in (out_inside_res)
  );

endmodule
